>>> rtl/core/xils_pkg.sv
// ----------------------------------------------------------------------------
// xils_pkg
// Types, opcode codes and decode helpers shared by the length scanner.
// ----------------------------------------------------------------------------
package xils_pkg;

  localparam int MAX_PREFIXES = 15;
  localparam int PFX_CNT_W    = $clog2(MAX_PREFIXES + 1);

  localparam logic [6:0] MIN_BYTES_RST = 7'd14;
  localparam logic       LONG_MODE_RST = 1'b1;

  // configuration register indexes
  localparam logic REG_MIN_BYTES = 1'b0;
  localparam logic REG_LONG_MODE = 1'b1;

  // prefix bytes
  localparam logic [7:0] PFX_LOCK  = 8'hF0;
  localparam logic [7:0] PFX_REPNE = 8'hF2;
  localparam logic [7:0] PFX_REP   = 8'hF3;
  localparam logic [7:0] PFX_CS    = 8'h2E;
  localparam logic [7:0] PFX_SS    = 8'h36;
  localparam logic [7:0] PFX_DS    = 8'h3E;
  localparam logic [7:0] PFX_ES    = 8'h26;
  localparam logic [7:0] PFX_FS    = 8'h64;
  localparam logic [7:0] PFX_GS    = 8'h65;
  localparam logic [7:0] PFX_OSZ   = 8'h66;
  localparam logic [7:0] PFX_ASZ   = 8'h67;
  localparam logic [3:0] REX_HI    = 4'h4;

  // opcodes and opcode groups (pattern under mask)
  localparam logic [7:0] OP_TWO_BYTE  = 8'h0F;
  localparam logic [7:0] OP_PUSH_IMM  = 8'h68;
  localparam logic [7:0] OP_JMP_SHORT = 8'hEB;
  localparam logic [7:0] OP_JMP_NEAR  = 8'hE9;
  localparam logic [7:0] OP_CALL_NEAR = 8'hE8;
  localparam logic [7:0] OP_INT3      = 8'hCC;
  localparam logic [7:0] MSK_MOV_IMM  = 8'hF7;
  localparam logic [7:0] PAT_MOV_IMM  = 8'hC7;
  localparam logic [7:0] MSK_NIB      = 8'hF0;
  localparam logic [7:0] PAT_JCC      = 8'h70;
  localparam logic [7:0] PAT_XCHG     = 8'h90;
  localparam logic [7:0] MSK_OCT      = 8'hF8;
  localparam logic [7:0] PAT_MOV_REG  = 8'hB8;
  localparam logic [7:0] PAT_PUSH_REG = 8'h50;
  localparam logic [7:0] MSK_PAIR     = 8'hFE;
  localparam logic [7:0] PAT_ADD_AL   = 8'h04;
  localparam logic [7:0] MSK_QUAD     = 8'hFC;
  localparam logic [7:0] PAT_GRP1     = 8'h80;
  localparam logic [3:0] JCC2_HI      = 4'h8;

  // ModRM fields
  localparam logic [1:0] MOD_MEM     = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_DISP32  = 2'd2;
  localparam logic [1:0] MOD_REG     = 2'd3;
  localparam logic [2:0] RM_SIB      = 3'd4;
  localparam logic [2:0] RM_NO_BASE  = 3'd5;

  typedef enum logic [5:0] {
    PH_PREFIX  = 6'b000001,
    PH_OPCODE2 = 6'b000010,
    PH_MODRM   = 6'b000100,
    PH_SIB     = 6'b001000,
    PH_DISP    = 6'b010000,
    PH_IMM     = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [PFX_CNT_W-1:0]   prefix_count;
    logic                   osz_seen;
    logic                   needs_modrm;
    logic [1:0]             mod_field;
    logic [2:0]             disp_left;
    logic [2:0]             imm_left;
    logic [4:0]             instr_bytes;
    logic [6:0]             total_bytes;
    logic                   done_flag;
  } scan_state_t;

  typedef struct packed {
    logic [4:0] instr_length;
    logic [6:0] total_length;
    logic       scan_done;
  } scan_result_t;

  typedef struct packed {
    logic       needs_modrm;
    logic [2:0] imm_left;
  } op_class_t;

  function automatic scan_state_t clear_instr(input scan_state_t s);
    scan_state_t r;
    r              = s;
    r.phase        = PH_PREFIX;
    r.prefix_count = '0;
    r.osz_seen     = 1'b0;
    r.needs_modrm  = 1'b0;
    r.mod_field    = '0;
    r.disp_left    = '0;
    r.imm_left     = '0;
    r.instr_bytes  = '0;
    return r;
  endfunction

  function automatic logic is_prefix(input logic [7:0] b, input logic long_mode);
    logic r;
    case (b) inside
      PFX_LOCK, PFX_REPNE, PFX_REP, PFX_CS, PFX_SS, PFX_DS, PFX_ES,
      PFX_FS, PFX_GS, PFX_OSZ, PFX_ASZ: r = 1'b1;
      default:                          r = long_mode && (b[7:4] == REX_HI);
    endcase
    return r;
  endfunction

  function automatic op_class_t classify(input logic [7:0] op, input logic osz_seen);
    op_class_t  c;
    logic [2:0] osz;
    osz           = osz_seen ? 3'd2 : 3'd4;
    c.needs_modrm = 1'b0;
    c.imm_left    = 3'd0;
    if ((op & MSK_MOV_IMM) == PAT_MOV_IMM) begin
      c.needs_modrm = 1'b1;
      c.imm_left    = osz;
    end else if (op == OP_PUSH_IMM) begin
      c.imm_left = osz;
    end else if ((op & MSK_NIB) == PAT_JCC) begin
      c.imm_left = 3'd1;
    end else if ((op & MSK_OCT) == PAT_MOV_REG) begin
      c.imm_left = osz;
    end else if ((op & MSK_PAIR) == PAT_ADD_AL) begin
      c.imm_left = 3'd1;
    end else if ((op & MSK_QUAD) == PAT_GRP1) begin
      c.needs_modrm = 1'b1;
      c.imm_left    = 3'd1;
    end else if (op == OP_JMP_SHORT) begin
      c.imm_left = 3'd1;
    end else if (op == OP_JMP_NEAR || op == OP_CALL_NEAR) begin
      c.imm_left = osz;
    end else if ((op & MSK_OCT) == PAT_PUSH_REG) begin
      c.needs_modrm = 1'b0;
    end else if (op[7:6] != 2'b11) begin
      c.needs_modrm = 1'b1;
    end else if ((op & MSK_NIB) == PAT_XCHG) begin
      c.needs_modrm = 1'b0;
    end else if (op != OP_INT3) begin
      c.needs_modrm = 1'b1;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/xils_step.sv
// ----------------------------------------------------------------------------
// xils_step
// Next-state and result logic for one code byte of the length scanner.
// ----------------------------------------------------------------------------
module xils_step import xils_pkg::*; (
  input  scan_state_t  st_i,
  input  logic [7:0]   code_byte_i,
  input  logic         scan_start_i,
  input  logic [6:0]   min_bytes_i,
  input  logic         long_mode_i,
  output scan_state_t  st_o,
  output logic         res_vld_o,
  output scan_result_t res_o
);

  scan_state_t s;
  op_class_t   cls;
  logic        go;
  logic        fin;
  logic [7:0]  sum;
  logic [1:0]  mod;
  logic [2:0]  rm;

  assign mod = code_byte_i[7:6];
  assign rm  = code_byte_i[2:0];

  always_comb begin
    s     = st_i;
    go    = 1'b0;
    fin   = 1'b0;
    sum   = '0;
    res_o = '0;
    if (scan_start_i) begin
      s             = clear_instr(s);
      s.total_bytes = '0;
      s.done_flag   = (min_bytes_i == 7'd0);
    end
    cls = classify(code_byte_i, s.osz_seen);
    if (!s.done_flag) begin
      s.instr_bytes = s.instr_bytes + 5'd1;
      unique case (s.phase)
        PH_PREFIX: begin
          if ((s.prefix_count < PFX_CNT_W'(MAX_PREFIXES)) &&
              is_prefix(code_byte_i, long_mode_i)) begin
            s.prefix_count = s.prefix_count + 1'b1;
            if (code_byte_i == PFX_OSZ) s.osz_seen = 1'b1;
          end else if (code_byte_i == OP_TWO_BYTE) begin
            s.phase = PH_OPCODE2;
          end else begin
            s.needs_modrm = cls.needs_modrm;
            s.imm_left    = cls.imm_left;
            go            = 1'b1;
          end
        end
        PH_OPCODE2: begin
          if (code_byte_i[7:4] == JCC2_HI) begin
            s.needs_modrm = 1'b0;
            s.imm_left    = s.osz_seen ? 3'd2 : 3'd4;
          end else begin
            s.needs_modrm = 1'b1;
            s.imm_left    = 3'd0;
          end
          go = 1'b1;
        end
        PH_MODRM: begin
          s.mod_field = mod;
          case (mod)
            MOD_DISP8:  s.disp_left = 3'd1;
            MOD_DISP32: s.disp_left = 3'd4;
            default:    s.disp_left = 3'd0;
          endcase
          if (mod != MOD_REG && rm == RM_SIB) begin
            s.phase = PH_SIB;
          end else begin
            if (mod == MOD_MEM && rm == RM_NO_BASE) s.disp_left = 3'd4;
            go = 1'b1;
          end
        end
        PH_SIB: begin
          if (s.mod_field == MOD_MEM && rm == RM_NO_BASE) s.disp_left = 3'd4;
          go = 1'b1;
        end
        PH_DISP: begin
          if (s.disp_left != 3'd0) s.disp_left = s.disp_left - 3'd1;
          if (s.disp_left == 3'd0) go = 1'b1;
        end
        PH_IMM: begin
          if (s.imm_left != 3'd0) s.imm_left = s.imm_left - 3'd1;
          if (s.imm_left == 3'd0) fin = 1'b1;
        end
        default: s = clear_instr(s);
      endcase
      if (go) begin
        if (s.needs_modrm) begin
          s.needs_modrm = 1'b0;
          s.phase       = PH_MODRM;
        end else if (s.disp_left != 3'd0) begin
          s.phase = PH_DISP;
        end else if (s.imm_left != 3'd0) begin
          s.phase = PH_IMM;
        end else begin
          fin = 1'b1;
        end
      end
      if (fin) begin
        sum                = {1'b0, s.total_bytes} + {3'b000, s.instr_bytes};
        s.total_bytes      = sum[7] ? 7'h7F : sum[6:0];
        s.done_flag        = (s.total_bytes >= min_bytes_i);
        res_o.instr_length = s.instr_bytes;
        res_o.total_length = s.total_bytes;
        res_o.scan_done    = s.done_flag;
        s                  = clear_instr(s);
      end
    end
    st_o      = s;
    res_vld_o = fin;
  end

endmodule

>>> rtl/core/x86_instruction_length_scan.sv
// ----------------------------------------------------------------------------
// x86_instruction_length_scan
// Byte-serial x86 instruction length scanner with running total.
// ----------------------------------------------------------------------------
// Feed code bytes one per cycle; assert in_scan_start with the first byte of
// a scan. One byte is accepted every cycle while the result register is free
// or being drained; a result is valid in the cycle after the edge that
// accepts the byte ending an instruction, which comes from the input register
// (input register, then result register). The rate is set by the state update
// in the combinational step logic. Bytes are ignored once the scan is done
// until the next scan start. Write configuration only when idle.
module x86_instruction_length_scan import xils_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_code_byte,
  input  logic       in_scan_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_instr_length,
  output logic [6:0] out_total_length,
  output logic       out_scan_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  logic         in_vld_r;
  logic [7:0]   byte_r;
  logic         start_r;
  logic [6:0]   min_bytes_r;
  logic         long_mode_r;
  scan_state_t  state_r;
  scan_state_t  state_nxt;
  scan_state_t  state_rst;
  scan_result_t res_nxt;
  scan_result_t res_r;
  logic         res_vld;
  logic         out_vld_r;
  logic         adv;

  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_rst           = clear_instr('0);
    state_rst.done_flag = 1'b1;
  end

  xils_step u_step (
    .st_i         (state_r),
    .code_byte_i  (byte_r),
    .scan_start_i (start_r),
    .min_bytes_i  (min_bytes_r),
    .long_mode_i  (long_mode_r),
    .st_o         (state_nxt),
    .res_vld_o    (res_vld),
    .res_o        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bytes_r <= MIN_BYTES_RST;
      long_mode_r <= LONG_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_BYTES: min_bytes_r <= cfg_data;
        REG_LONG_MODE: long_mode_r <= cfg_data[0];
        default:       min_bytes_r <= min_bytes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= state_rst;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (adv) state_r <= state_nxt;
      if (out_vld_r && out_ready) out_vld_r <= 1'b0;
      if (adv && res_vld) out_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r  <= in_code_byte;
      start_r <= in_scan_start;
    end
    if (adv && res_vld) res_r <= res_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_instr_length = res_r.instr_length;
  assign out_total_length = res_r.total_length;
  assign out_scan_done    = res_r.scan_done;

  a_total_covers_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.total_length >= {2'b00, res_r.instr_length}))
    else $error("total below instruction length");

  a_done_matches_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.scan_done == (res_r.total_length >= min_bytes_r)))
    else $error("scan_done disagrees with minimum");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_vld) |=> (state_r.instr_bytes == 5'd0 && state_r.phase == PH_PREFIX))
    else $error("instruction state not cleared after result");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && state_r.done_flag && !start_r) |-> !res_vld)
    else $error("result while scan idle");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_vld) |-> (res_nxt.instr_length != 5'd0))
    else $error("zero-length instruction");

endmodule
